@@ design/ibmt_pkg.sv @@
`timescale 1ns / 1ps
// Package for the inode block map translator: map geometry, opcodes, status codes,
// register indexes and the command/status structs between controller and datapath.
// No dependencies.
package ibmt_pkg;

  // Map geometry; INDIRECT_ENTRIES is a power of two
  localparam int INDIRECT_ENTRIES  = 1024;
  localparam int DIRECT_SLOTS      = 6;
  localparam int SECTORS_PER_BLOCK = 8;
  localparam int SLOT_COUNT        = DIRECT_SLOTS + 2;
  localparam int IDX_W             = $clog2(INDIRECT_ENTRIES);
  localparam int SLOT_W            = $clog2(SLOT_COUNT);

  // Field widths
  localparam int WORD_W   = 32;
  localparam int FBLK_W   = 21;
  localparam int SIDX_W   = 10;
  localparam int SECTOR_W = 36;
  localparam int MAP_W    = 40;
  localparam int CFG_W    = 1;

  localparam logic [MAP_W-1:0] SINGLE_LIMIT =
    MAP_W'(DIRECT_SLOTS) + MAP_W'(INDIRECT_ENTRIES);
  localparam logic [MAP_W-1:0] DOUBLE_LIMIT =
    SINGLE_LIMIT + MAP_W'(INDIRECT_ENTRIES) * MAP_W'(INDIRECT_ENTRIES);

  localparam logic [1:0] OP_TRANSLATE = 2'd0;
  localparam logic [1:0] OP_LOAD      = 2'd1;
  localparam logic [1:0] OP_FILL      = 2'd2;

  localparam logic [CFG_W-1:0] CFG_START = 1'b0;
  localparam logic [CFG_W-1:0] CFG_COUNT = 1'b1;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FETCH  = 3'd1,
    ST_RANGE  = 3'd2,
    ST_TOOBIG = 3'd3,
    ST_ACK    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD1,
    S_RD2,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic rd2;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic lookup;
    logic dbl_region;
    logic dbl_hit;
  } sts_t;

endpackage

@@ design/ibmt_ram.sv @@
`timescale 1ns / 1ps
// Generic RAM: one write port, one read port with registered read data.
// No dependencies.
module ibmt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/ibmt_ctrl.sv @@
`timescale 1ns / 1ps
// Controller of the inode block map translator: sequences capture, execute, cache reads
// and result hand-off. Depends on ibmt_pkg.
module ibmt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  ibmt_pkg::sts_t sts,
  output ibmt_pkg::cmd_t cmd
);

  ibmt_pkg::state_t state, state_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ibmt_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ibmt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ibmt_pkg::S_EXEC;
        end
      end
      ibmt_pkg::S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.lookup ? ibmt_pkg::S_RD1 : ibmt_pkg::S_FINISH;
      end
      ibmt_pkg::S_RD1: begin
        if (sts.dbl_region && sts.dbl_hit) begin
          cmd.rd2    = 1'b1;
          state_next = ibmt_pkg::S_RD2;
        end else begin
          state_next = ibmt_pkg::S_FINISH;
        end
      end
      ibmt_pkg::S_RD2: begin
        state_next = ibmt_pkg::S_FINISH;
      end
      ibmt_pkg::S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ibmt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ibmt_pkg::S_IDLE;
      end
    endcase
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

`ifndef SYNTH
  a_capture_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state == ibmt_pkg::S_EXEC)
    else $error("capture not followed by execute");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> !cmd.out_load || $past(cmd.out_load) == 1'b0)
    else $error("pending result overwritten");

  a_rd2_after_hit: assert property (@(posedge clk) disable iff (rst)
    state == ibmt_pkg::S_RD2 |-> $past(state) == ibmt_pkg::S_RD1 && $past(sts.dbl_hit))
    else $error("second cache read without double-indirect hit");

  a_load_clears_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid && in_ready)
    else $error("result load did not present a transaction");
`endif

endmodule

@@ design/ibmt_datapath.sv @@
`timescale 1ns / 1ps
// Datapath of the inode block map translator: inode slots, cache tags, two cache RAMs,
// partition registers and the result register. Depends on ibmt_pkg and ibmt_ram.
module ibmt_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [1:0]                      opcode,
  input  logic [ibmt_pkg::FBLK_W-1:0]     file_block,
  input  logic [ibmt_pkg::SIDX_W-1:0]     slot_index,
  input  logic                            cache_select,
  input  logic [ibmt_pkg::WORD_W-1:0]     word_value,
  input  logic [ibmt_pkg::WORD_W-1:0]     source_block,
  input  logic                            last_word,
  input  logic                            cfg_write,
  input  logic [ibmt_pkg::CFG_W-1:0]      cfg_index,
  input  logic [ibmt_pkg::WORD_W-1:0]     cfg_data,
  input  ibmt_pkg::cmd_t                  cmd,
  output ibmt_pkg::sts_t                  sts,
  output logic [2:0]                      status,
  output logic                            fetch_target,
  output logic [ibmt_pkg::WORD_W-1:0]     disk_block,
  output logic [ibmt_pkg::SECTOR_W-1:0]   disk_sector
);

  localparam int MW = ibmt_pkg::MAP_W;
  localparam int IW = ibmt_pkg::IDX_W;

  logic [1:0]                      op_q;
  logic [ibmt_pkg::FBLK_W-1:0]     fb_q;
  logic [ibmt_pkg::SIDX_W-1:0]     idx_q;
  logic                            sel_q;
  logic [ibmt_pkg::WORD_W-1:0]     word_q;
  logic [ibmt_pkg::WORD_W-1:0]     src_q;
  logic                            last_q;

  logic [ibmt_pkg::WORD_W-1:0] slots [ibmt_pkg::SLOT_COUNT];
  logic [ibmt_pkg::WORD_W-1:0] single_tag, double_tag;
  logic                        single_valid, double_valid;
  logic [ibmt_pkg::WORD_W-1:0] part_start, part_count;

  logic [MW-1:0] fbx, rel1, rel2;
  logic          is_direct, is_single, is_double, is_translate;
  logic          slot_ok, entry_ok, fill_single, fill_double;
  logic          single_re, double_re;
  logic [IW-1:0] single_raddr, entry_addr;
  logic [ibmt_pkg::WORD_W-1:0] single_rdata, double_rdata, slot6, slot7;
  logic          single_hit, dbl_hit, ind_hit;

  ibmt_pkg::status_t           st_base, st_fin;
  logic                        tgt_base, tgt_fin, zero_res, in_range;
  logic [ibmt_pkg::WORD_W-1:0] blk, blk_fin;
  logic [MW-1:0]               sec_raw, sec_full;

  assign fbx       = MW'(fb_q);
  assign rel1      = fbx - MW'(ibmt_pkg::DIRECT_SLOTS);
  assign rel2      = fbx - ibmt_pkg::SINGLE_LIMIT;
  assign is_direct = fbx < MW'(ibmt_pkg::DIRECT_SLOTS);
  assign is_single = !is_direct && (fbx < ibmt_pkg::SINGLE_LIMIT);
  assign is_double = !is_direct && !is_single && (fbx < ibmt_pkg::DOUBLE_LIMIT);
  assign is_translate = op_q == ibmt_pkg::OP_TRANSLATE;

  assign slot6 = slots[ibmt_pkg::DIRECT_SLOTS];
  assign slot7 = slots[ibmt_pkg::DIRECT_SLOTS + 1];
  assign single_hit = single_valid && (single_tag == slot6);
  assign dbl_hit    = double_valid && (double_tag == slot7);
  assign ind_hit    = single_valid && (single_tag == double_rdata);

  assign sts.lookup     = is_translate && (is_single || is_double);
  assign sts.dbl_region = is_double;
  assign sts.dbl_hit    = dbl_hit;

  assign slot_ok     = 32'(idx_q) < 32'(ibmt_pkg::SLOT_COUNT);
  assign entry_ok    = 32'(idx_q) < 32'(ibmt_pkg::INDIRECT_ENTRIES);
  assign entry_addr  = IW'(idx_q);
  assign fill_single = cmd.exec && (op_q == ibmt_pkg::OP_FILL) && !sel_q;
  assign fill_double = cmd.exec && (op_q == ibmt_pkg::OP_FILL) && sel_q;

  assign single_re    = (cmd.exec && is_translate && is_single) || cmd.rd2;
  assign single_raddr = cmd.rd2 ? rel2[IW-1:0] : rel1[IW-1:0];
  assign double_re    = cmd.exec && is_translate && is_double;

  ibmt_ram #(.WIDTH(ibmt_pkg::WORD_W), .DEPTH(ibmt_pkg::INDIRECT_ENTRIES)) u_single_ram (
    .clk   (clk),
    .we    (fill_single && entry_ok),
    .waddr (entry_addr),
    .wdata (word_q),
    .re    (single_re),
    .raddr (single_raddr),
    .rdata (single_rdata)
  );

  ibmt_ram #(.WIDTH(ibmt_pkg::WORD_W), .DEPTH(ibmt_pkg::INDIRECT_ENTRIES)) u_double_ram (
    .clk   (clk),
    .we    (fill_double && entry_ok),
    .waddr (entry_addr),
    .wdata (word_q),
    .re    (double_re),
    .raddr (rel2[2*IW-1:IW]),
    .rdata (double_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= opcode;
      fb_q   <= file_block;
      idx_q  <= slot_index;
      sel_q  <= cache_select;
      word_q <= word_value;
      src_q  <= source_block;
      last_q <= last_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ibmt_pkg::SLOT_COUNT; i++) begin
        slots[i] <= '0;
      end
      single_tag   <= '0;
      double_tag   <= '0;
      single_valid <= 1'b0;
      double_valid <= 1'b0;
      part_start   <= '0;
      part_count   <= '0;
    end else begin
      if (cmd.exec && (op_q == ibmt_pkg::OP_LOAD) && slot_ok) begin
        slots[idx_q[ibmt_pkg::SLOT_W-1:0]] <= word_q;
      end
      if (fill_single) begin
        single_valid <= last_q;
        if (last_q) begin
          single_tag <= src_q;
        end
      end
      if (fill_double) begin
        double_valid <= last_q;
        if (last_q) begin
          double_tag <= src_q;
        end
      end
      if (cfg_write) begin
        unique case (cfg_index)
          ibmt_pkg::CFG_START: part_start <= cfg_data;
          ibmt_pkg::CFG_COUNT: part_count <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    st_base  = ibmt_pkg::ST_OK;
    tgt_base = 1'b0;
    blk      = '0;
    zero_res = 1'b0;
    if (!is_translate) begin
      st_base  = ibmt_pkg::ST_ACK;
      zero_res = 1'b1;
    end else if (is_direct) begin
      blk = slots[fb_q[ibmt_pkg::SLOT_W-1:0]];
    end else if (is_single) begin
      if (!single_hit) begin
        st_base = ibmt_pkg::ST_FETCH;
        blk     = slot6;
      end else begin
        blk = single_rdata;
      end
    end else if (is_double) begin
      if (!dbl_hit) begin
        st_base  = ibmt_pkg::ST_FETCH;
        tgt_base = 1'b1;
        blk      = slot7;
      end else if (!ind_hit) begin
        st_base = ibmt_pkg::ST_FETCH;
        blk     = double_rdata;
      end else begin
        blk = single_rdata;
      end
    end else begin
      st_base  = ibmt_pkg::ST_TOOBIG;
      zero_res = 1'b1;
    end

    sec_raw  = MW'(blk) * MW'(ibmt_pkg::SECTORS_PER_BLOCK);
    sec_full = sec_raw + MW'(part_start);
    in_range = (sec_raw + MW'(ibmt_pkg::SECTORS_PER_BLOCK)) <= MW'(part_count);

    if (zero_res) begin
      st_fin  = st_base;
      tgt_fin = 1'b0;
      blk_fin = '0;
    end else if (!in_range) begin
      st_fin  = ibmt_pkg::ST_RANGE;
      tgt_fin = 1'b0;
      blk_fin = blk;
    end else begin
      st_fin  = st_base;
      tgt_fin = tgt_base;
      blk_fin = blk;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status       <= st_fin;
      fetch_target <= tgt_fin;
      disk_block   <= blk_fin;
      disk_sector  <= zero_res ? '0 : sec_full[ibmt_pkg::SECTOR_W-1:0];
    end
  end

endmodule

@@ design/inode_block_map_translator.sv @@
`timescale 1ns / 1ps
// Top level of the inode block map translator: controller and datapath.
// Depends on ibmt_pkg, ibmt_ctrl, ibmt_datapath.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    opcode .. last_word
//   out      output     out_valid/out_ready  status, fetch_target, disk_block, disk_sector
//   cfg      input      cfg_write            cfg_index, cfg_data
//
// A transaction passes through the idle (capture), execute and finish states, and its result is
// registered in finish for loads, fills, direct and oversize blocks; a first cache read state is
// added for the single-indirect range and a double-indirect miss, and a second one for a
// double-indirect hit, since the two registered reads of the cache RAMs depend on each other.
// Reset clears slots, tags, valid marks and partition registers at once; cache RAMs are not cleared.
// A result waiting on out_ready holds; the next transaction is accepted and runs up to its
// hand-off meanwhile.
module inode_block_map_translator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    opcode,
  input  logic [ibmt_pkg::FBLK_W-1:0]   file_block,
  input  logic [ibmt_pkg::SIDX_W-1:0]   slot_index,
  input  logic                          cache_select,
  input  logic [ibmt_pkg::WORD_W-1:0]   word_value,
  input  logic [ibmt_pkg::WORD_W-1:0]   source_block,
  input  logic                          last_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    status,
  output logic                          fetch_target,
  output logic [ibmt_pkg::WORD_W-1:0]   disk_block,
  output logic [ibmt_pkg::SECTOR_W-1:0] disk_sector,
  input  logic                          cfg_write,
  input  logic [ibmt_pkg::CFG_W-1:0]    cfg_index,
  input  logic [ibmt_pkg::WORD_W-1:0]   cfg_data
);

  ibmt_pkg::cmd_t cmd;
  ibmt_pkg::sts_t sts;

  ibmt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ibmt_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .opcode       (opcode),
    .file_block   (file_block),
    .slot_index   (slot_index),
    .cache_select (cache_select),
    .word_value   (word_value),
    .source_block (source_block),
    .last_word    (last_word),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .sts          (sts),
    .status       (status),
    .fetch_target (fetch_target),
    .disk_block   (disk_block),
    .disk_sector  (disk_sector)
  );

endmodule

@@ sim/inode_block_map_translator_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for inode_block_map_translator: queue-fed driver, monitor
// and a map predictor with its own inode slots, caches, tags and valid marks.
// Depends on ibmt_pkg and the translator RTL only.
module inode_block_map_translator_test;

  localparam int PLAN        = 0;
  localparam int LIVE        = 1;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 150;
  localparam int HOLD_AT     = 400;

  typedef struct packed {
    logic [1:0]                  opcode;
    logic [ibmt_pkg::FBLK_W-1:0] file_block;
    logic [ibmt_pkg::SIDX_W-1:0] slot_index;
    logic                        cache_select;
    logic [ibmt_pkg::WORD_W-1:0] word_value;
    logic [ibmt_pkg::WORD_W-1:0] source_block;
    logic                        last_word;
  } map_req_t;

  typedef struct packed {
    ibmt_pkg::status_t             status;
    logic                          fetch_target;
    logic [ibmt_pkg::WORD_W-1:0]   disk_block;
    logic [ibmt_pkg::SECTOR_W-1:0] disk_sector;
  } map_result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [1:0]                    opcode = '0;
  logic [ibmt_pkg::FBLK_W-1:0]   file_block = '0;
  logic [ibmt_pkg::SIDX_W-1:0]   slot_index = '0;
  logic                          cache_select = 1'b0;
  logic [ibmt_pkg::WORD_W-1:0]   word_value = '0;
  logic [ibmt_pkg::WORD_W-1:0]   source_block = '0;
  logic                          last_word = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [2:0]                    status;
  logic                          fetch_target;
  logic [ibmt_pkg::WORD_W-1:0]   disk_block;
  logic [ibmt_pkg::SECTOR_W-1:0] disk_sector;
  logic                          cfg_write = 1'b0;
  logic [ibmt_pkg::CFG_W-1:0]    cfg_index = '0;
  logic [ibmt_pkg::WORD_W-1:0]   cfg_data = '0;

  // two copies of the map: PLAN runs ahead with the stimulus, LIVE follows acceptance
  bit [ibmt_pkg::WORD_W-1:0] slot_mem  [2][ibmt_pkg::SLOT_COUNT];
  bit [ibmt_pkg::WORD_W-1:0] cache_mem [2][2][ibmt_pkg::INDIRECT_ENTRIES];
  bit                        cache_wr  [2][2][ibmt_pkg::INDIRECT_ENTRIES];
  bit [ibmt_pkg::WORD_W-1:0] cache_tag [2][2];
  bit                        cache_ok  [2][2];
  logic [ibmt_pkg::WORD_W-1:0] part_start = '0;
  logic [ibmt_pkg::WORD_W-1:0] part_count = '0;

  map_req_t    pending_q [$];
  map_result_t results_due [$];
  map_req_t    on_port;
  map_result_t due_now;
  map_result_t got_want;
  bit          live_stray;
  int          filled [$];
  int unsigned queued = 0;
  int unsigned accepted = 0;
  int unsigned results_seen = 0;
  int unsigned errors = 0;
  int unsigned hold_left = 0;
  int unsigned quiet = 0;
  int unsigned status_seen [5];
  bit          calm = 1'b0;

  inode_block_map_translator DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .file_block(file_block), .slot_index(slot_index),
    .cache_select(cache_select), .word_value(word_value),
    .source_block(source_block), .last_word(last_word),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .fetch_target(fetch_target),
    .disk_block(disk_block), .disk_sector(disk_sector),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic map_result_t block_answer(input ibmt_pkg::status_t st, input logic tgt,
                                               input logic [ibmt_pkg::WORD_W-1:0] blk);
    map_result_t r;
    logic [63:0] first;
    first = 64'(blk) * 64'(ibmt_pkg::SECTORS_PER_BLOCK);
    r.disk_block = blk;
    r.disk_sector = ibmt_pkg::SECTOR_W'(first + 64'(part_start));
    if (first + 64'(ibmt_pkg::SECTORS_PER_BLOCK) <= 64'(part_count)) begin
      r.status = st;
      r.fetch_target = tgt;
    end else begin
      r.status = ibmt_pkg::ST_RANGE;
      r.fetch_target = 1'b0;
    end
    return r;
  endfunction

  // stray flags a read of a cache word that was never written
  function automatic void map_step(input int c, input map_req_t q, output map_result_t r,
                                   output bit stray);
    logic [ibmt_pkg::MAP_W-1:0]  fb;
    logic [ibmt_pkg::MAP_W-1:0]  rel;
    logic [ibmt_pkg::WORD_W-1:0] ind;
    logic [ibmt_pkg::IDX_W-1:0]  wi;
    r.status = ibmt_pkg::ST_ACK;
    r.fetch_target = 1'b0;
    r.disk_block = '0;
    r.disk_sector = '0;
    stray = 1'b0;
    fb = ibmt_pkg::MAP_W'(q.file_block);
    case (q.opcode)
      ibmt_pkg::OP_TRANSLATE: begin
        if (fb < ibmt_pkg::MAP_W'(ibmt_pkg::DIRECT_SLOTS)) begin
          r = block_answer(ibmt_pkg::ST_OK, 1'b0, slot_mem[c][fb[ibmt_pkg::SLOT_W-1:0]]);
        end else if (fb < ibmt_pkg::SINGLE_LIMIT) begin
          ind = slot_mem[c][ibmt_pkg::DIRECT_SLOTS];
          wi = ibmt_pkg::IDX_W'(fb - ibmt_pkg::MAP_W'(ibmt_pkg::DIRECT_SLOTS));
          if (!cache_ok[c][0] || cache_tag[c][0] != ind) begin
            r = block_answer(ibmt_pkg::ST_FETCH, 1'b0, ind);
          end else begin
            stray = !cache_wr[c][0][wi];
            r = block_answer(ibmt_pkg::ST_OK, 1'b0, cache_mem[c][0][wi]);
          end
        end else if (fb < ibmt_pkg::DOUBLE_LIMIT) begin
          rel = fb - ibmt_pkg::SINGLE_LIMIT;
          if (!cache_ok[c][1] ||
              cache_tag[c][1] != slot_mem[c][ibmt_pkg::DIRECT_SLOTS+1]) begin
            r = block_answer(ibmt_pkg::ST_FETCH, 1'b1, slot_mem[c][ibmt_pkg::DIRECT_SLOTS+1]);
          end else begin
            wi = rel[2*ibmt_pkg::IDX_W-1:ibmt_pkg::IDX_W];
            stray = !cache_wr[c][1][wi];
            ind = cache_mem[c][1][wi];
            wi = rel[ibmt_pkg::IDX_W-1:0];
            if (!cache_ok[c][0] || cache_tag[c][0] != ind) begin
              r = block_answer(ibmt_pkg::ST_FETCH, 1'b0, ind);
            end else begin
              stray = stray | !cache_wr[c][0][wi];
              r = block_answer(ibmt_pkg::ST_OK, 1'b0, cache_mem[c][0][wi]);
            end
          end
        end else begin
          r.status = ibmt_pkg::ST_TOOBIG;
        end
      end
      ibmt_pkg::OP_LOAD: begin
        if (int'(q.slot_index) < ibmt_pkg::SLOT_COUNT) begin
          slot_mem[c][q.slot_index[ibmt_pkg::SLOT_W-1:0]] = q.word_value;
        end
      end
      ibmt_pkg::OP_FILL: begin
        if (int'(q.slot_index) < ibmt_pkg::INDIRECT_ENTRIES) begin
          cache_mem[c][q.cache_select][q.slot_index] = q.word_value;
          cache_wr[c][q.cache_select][q.slot_index] = 1'b1;
        end
        cache_ok[c][q.cache_select] = q.last_word;
        if (q.last_word) begin
          cache_tag[c][q.cache_select] = q.source_block;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic map_req_t noise_req();
    map_req_t q;
    q.opcode = 2'($urandom_range(0, 3));
    q.file_block = ibmt_pkg::FBLK_W'($urandom());
    q.slot_index = ibmt_pkg::SIDX_W'($urandom());
    q.cache_select = 1'($urandom());
    q.word_value = $urandom();
    q.source_block = $urandom();
    q.last_word = 1'($urandom());
    return q;
  endfunction

  function automatic map_req_t translate_req(input int unsigned fb);
    map_req_t q;
    q = noise_req();
    q.opcode = ibmt_pkg::OP_TRANSLATE;
    q.file_block = ibmt_pkg::FBLK_W'(fb);
    return q;
  endfunction

  function automatic map_req_t load_req(input int unsigned slot,
                                        input logic [ibmt_pkg::WORD_W-1:0] val);
    map_req_t q;
    q = noise_req();
    q.opcode = ibmt_pkg::OP_LOAD;
    q.slot_index = ibmt_pkg::SIDX_W'(slot);
    q.word_value = val;
    return q;
  endfunction

  function automatic map_req_t fill_req(input logic sel, input int unsigned idx,
                                        input logic [ibmt_pkg::WORD_W-1:0] val,
                                        input logic [ibmt_pkg::WORD_W-1:0] src,
                                        input logic last);
    map_req_t q;
    q = noise_req();
    q.opcode = ibmt_pkg::OP_FILL;
    q.cache_select = sel;
    q.slot_index = ibmt_pkg::SIDX_W'(idx);
    q.word_value = val;
    q.source_block = src;
    q.last_word = last;
    return q;
  endfunction

  // mostly blocks inside a small partition, some at its upper edge, some anywhere
  function automatic logic [ibmt_pkg::WORD_W-1:0] pick_block();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return ibmt_pkg::WORD_W'($urandom_range(0, 'hFFFF));
    if (roll < 88) begin
      return part_count[ibmt_pkg::WORD_W-1:3] - ibmt_pkg::WORD_W'($urandom_range(0, 1));
    end
    return $urandom();
  endfunction

  task automatic queue_req(input map_req_t q);
    map_result_t r;
    bit stray;
    map_step(PLAN, q, r, stray);
    if (stray) begin
      q.file_block = ibmt_pkg::FBLK_W'($urandom_range(0, ibmt_pkg::DIRECT_SLOTS - 1));
      map_step(PLAN, q, r, stray);
    end
    pending_q.push_back(q);
    queued++;
  endtask

  task automatic fill_words(input logic sel, input logic [ibmt_pkg::WORD_W-1:0] src,
                            input int n, input bit seal);
    int idx;
    filled.delete();
    for (int k = 0; k < n; k++) begin
      idx = $urandom_range(0, ibmt_pkg::INDIRECT_ENTRIES - 1);
      filled.push_back(idx);
      queue_req(fill_req(sel, idx, pick_block(), src, seal && k == n - 1));
    end
  endtask

  task automatic single_run();
    logic [ibmt_pkg::WORD_W-1:0] ind;
    ind = pick_block();
    if ($urandom_range(0, 1)) queue_req(load_req(ibmt_pkg::DIRECT_SLOTS, ind));
    else ind = slot_mem[PLAN][ibmt_pkg::DIRECT_SLOTS];
    queue_req(translate_req(ibmt_pkg::DIRECT_SLOTS +
                            $urandom_range(0, ibmt_pkg::INDIRECT_ENTRIES - 1)));
    fill_words(1'b0, ($urandom_range(0, 9) == 0) ? $urandom() : ind, $urandom_range(1, 6),
               $urandom_range(0, 9) != 0);
    repeat ($urandom_range(1, 3)) begin
      queue_req(translate_req(ibmt_pkg::DIRECT_SLOTS +
                              filled[$urandom_range(0, filled.size() - 1)]));
    end
  endtask

  task automatic double_run();
    logic [ibmt_pkg::WORD_W-1:0] dbl;
    logic [ibmt_pkg::WORD_W-1:0] ind;
    int unsigned base;
    dbl = pick_block();
    if ($urandom_range(0, 1)) queue_req(load_req(ibmt_pkg::DIRECT_SLOTS + 1, dbl));
    else dbl = slot_mem[PLAN][ibmt_pkg::DIRECT_SLOTS+1];
    queue_req(translate_req(int'(ibmt_pkg::SINGLE_LIMIT) +
                            $urandom_range(0, ibmt_pkg::INDIRECT_ENTRIES *
                                              ibmt_pkg::INDIRECT_ENTRIES - 1)));
    fill_words(1'b1, ($urandom_range(0, 9) == 0) ? $urandom() : dbl, $urandom_range(1, 4),
               $urandom_range(0, 9) != 0);
    base = filled[$urandom_range(0, filled.size() - 1)];
    ind = cache_mem[PLAN][1][base];
    base = int'(ibmt_pkg::SINGLE_LIMIT) + base * ibmt_pkg::INDIRECT_ENTRIES;
    queue_req(translate_req(base + $urandom_range(0, ibmt_pkg::INDIRECT_ENTRIES - 1)));
    fill_words(1'b0, ind, $urandom_range(1, 5), $urandom_range(0, 9) != 0);
    repeat ($urandom_range(1, 3)) begin
      queue_req(translate_req(base + filled[$urandom_range(0, filled.size() - 1)]));
    end
  endtask

  task automatic random_phase(input int unsigned n);
    int unsigned first;
    int unsigned roll;
    int unsigned s;
    first = queued;
    while (queued - first < n) begin
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        repeat ($urandom_range(1, 3)) queue_req(noise_req());
      end else if (roll < 35) begin
        s = $urandom_range(0, ibmt_pkg::DIRECT_SLOTS - 1);
        queue_req(load_req(s, pick_block()));
        queue_req(translate_req(s));
      end else if (roll < 65) begin
        single_run();
      end else begin
        double_run();
      end
    end
  endtask

  task automatic write_reg(input logic [ibmt_pkg::CFG_W-1:0] idx,
                           input logic [ibmt_pkg::WORD_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == ibmt_pkg::CFG_START) part_start = val;
    else part_count = val;
  endtask

  // hold until every queued transaction has been accepted and its result checked
  task automatic wait_idle();
    while (accepted != queued || results_due.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    if (errors <= 100) begin
      $display("result %0d: %s is 0x%0h, predicted 0x%0h", results_seen, what, got, want);
    end
  endtask

  // driver: hold the offered transaction until taken, then advance or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        map_step(LIVE, on_port, due_now, live_stray);
        results_due.push_back(due_now);
        accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_q.size() != 0 && (calm || $urandom_range(0, 99) >= 35)) begin
          on_port = pending_q.pop_front();
          opcode <= on_port.opcode;
          file_block <= on_port.file_block;
          slot_index <= on_port.slot_index;
          cache_select <= on_port.cache_select;
          word_value <= on_port.word_value;
          source_block <= on_port.source_block;
          last_word <= on_port.last_word;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (results_due.size() == 0) begin
          report_mismatch("unpredicted result, status", 64'(status), 64'(0));
        end else begin
          got_want = results_due.pop_front();
          if (status !== got_want.status)
            report_mismatch("status", 64'(status), 64'(got_want.status));
          if (fetch_target !== got_want.fetch_target)
            report_mismatch("fetch_target", 64'(fetch_target), 64'(got_want.fetch_target));
          if (disk_block !== got_want.disk_block)
            report_mismatch("disk_block", 64'(disk_block), 64'(got_want.disk_block));
          if (disk_sector !== got_want.disk_sector)
            report_mismatch("disk_sector", 64'(disk_sector), 64'(got_want.disk_sector));
          status_seen[got_want.status]++;
        end
        if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || $urandom_range(0, 99) >= 35;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet == STALL_LIMIT) begin
      $display("no transaction for %0d cycles", STALL_LIMIT);
      $display("inode_block_map_translator_test NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    write_reg(ibmt_pkg::CFG_START, 32'h100);
    write_reg(ibmt_pkg::CFG_COUNT, 32'h8_0000);
    queue_req(translate_req(0));
    queue_req(translate_req(2097151));
    queue_req(translate_req(int'(ibmt_pkg::DOUBLE_LIMIT)));
    queue_req(translate_req(int'(ibmt_pkg::DOUBLE_LIMIT) - 1));
    queue_req(translate_req(ibmt_pkg::DIRECT_SLOTS));
    queue_req(load_req(5, 32'hFFFF));
    queue_req(load_req(4, 32'h1_0000));
    queue_req(translate_req(5));
    queue_req(translate_req(4));
    queue_req(load_req(ibmt_pkg::SLOT_COUNT, 32'hDEAD));
    queue_req(load_req(1023, 32'hFFFF_FFFF));
    queue_req('1);
    queue_req(load_req(ibmt_pkg::DIRECT_SLOTS, 32'hFFFF_FFFF));
    queue_req(translate_req(ibmt_pkg::DIRECT_SLOTS + 3));
    queue_req(load_req(ibmt_pkg::DIRECT_SLOTS, 32'h1234));
    queue_req(fill_req(1'b0, 0, 32'h42, 32'h0, 1'b0));
    queue_req(fill_req(1'b0, ibmt_pkg::INDIRECT_ENTRIES - 1, 32'hFFFF, 32'h1234, 1'b1));
    queue_req(translate_req(ibmt_pkg::DIRECT_SLOTS));
    queue_req(translate_req(ibmt_pkg::DIRECT_SLOTS + ibmt_pkg::INDIRECT_ENTRIES - 1));
    queue_req(load_req(ibmt_pkg::DIRECT_SLOTS + 1, 32'h2000));
    queue_req(translate_req(int'(ibmt_pkg::SINGLE_LIMIT)));
    queue_req(fill_req(1'b1, 0, 32'h1234, 32'h2000, 1'b1));
    queue_req(translate_req(int'(ibmt_pkg::SINGLE_LIMIT)));
    queue_req(translate_req(int'(ibmt_pkg::SINGLE_LIMIT) + ibmt_pkg::INDIRECT_ENTRIES - 1));
    queue_req(fill_req(1'b0, 5, 32'h7, 32'h1234, 1'b0));
    queue_req(translate_req(ibmt_pkg::DIRECT_SLOTS));
    wait_idle();

    calm = 1'b1;
    write_reg(ibmt_pkg::CFG_START, 32'h0);
    write_reg(ibmt_pkg::CFG_COUNT, 32'hFFFF_FFFF);
    random_phase(250);
    wait_idle();
    calm = 1'b0;

    write_reg(ibmt_pkg::CFG_START, 32'hFFFF_FFFF);
    write_reg(ibmt_pkg::CFG_COUNT, 32'h8_0000);
    random_phase(250);
    wait_idle();

    write_reg(ibmt_pkg::CFG_START, 32'h0);
    write_reg(ibmt_pkg::CFG_COUNT, 32'h0);
    random_phase(120);
    wait_idle();

    write_reg(ibmt_pkg::CFG_START, $urandom());
    write_reg(ibmt_pkg::CFG_COUNT, $urandom_range('h4_0000, 'h20_0000));
    random_phase(130);
    wait_idle();
    repeat (10) @(posedge clk);

    $display("%0d transactions in, %0d results checked over 5 partition settings",
             accepted, results_seen);
    $display("translated %0d, fetch %0d, out of range %0d, too large %0d, acknowledged %0d",
             status_seen[ibmt_pkg::ST_OK], status_seen[ibmt_pkg::ST_FETCH],
             status_seen[ibmt_pkg::ST_RANGE], status_seen[ibmt_pkg::ST_TOOBIG],
             status_seen[ibmt_pkg::ST_ACK]);
    if (errors == 0) begin
      $display("inode_block_map_translator_test OK");
    end else begin
      $display("inode_block_map_translator_test NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/ibmt_pkg.sv
design/ibmt_ram.sv
design/ibmt_ctrl.sv
design/ibmt_datapath.sv
design/inode_block_map_translator.sv
sim/inode_block_map_translator_test.sv
